FILE: hw/rtl/ubt_pkg.sv
// Shared types and constants for the UUID base table.
`default_nettype none

package ubt_pkg;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} ubt_uuid_t;

	// Bluetooth SIG base 00000000-0000-1000-8000-00805F9B34FB.
	localparam logic [63:0] SIG_BASE_LOW  = 64'h8000_0080_5F9B_34FB;
	localparam logic [63:0] SIG_BASE_HIGH = 64'h0000_0000_0000_1000;

	localparam logic [2:0] REQ_FIND   = 3'd0;
	localparam logic [2:0] REQ_ADD    = 3'd1;
	localparam logic [2:0] REQ_GET    = 3'd2;
	localparam logic [2:0] REQ_EXPAND = 3'd3;
	localparam logic [2:0] REQ_COMP   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_BADIDX   = 2'd3;

	// Bytes 12-13 sit at bits 47:32 of the high half.
	localparam logic [63:0] SHORT16_CLEAR = 64'hFFFF_0000_FFFF_FFFF;

endpackage

`default_nettype wire

FILE: hw/rtl/ubt_store.sv
// Base table storage: entry 0 fixed to the SIG base, the rest written on add or compress.
`default_nettype none

module ubt_store
	import ubt_pkg::*;
#(
	parameter int ENTRIES = 4,
	parameter int IDX_W   = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] rd_addr,
	output ubt_uuid_t             rd_data_q,
	output logic                  rd_valid_q,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  ubt_uuid_t             wr_data
);

	ubt_uuid_t          mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= ENTRIES'(1);
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_addr];
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Entry 0 is never written; a read of address 0 returns the fixed SIG base.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_addr == '0) begin
			rd_data_q <= '{hi: SIG_BASE_HIGH, lo: SIG_BASE_LOW};
		end else begin
			rd_data_q <= mem[rd_addr];
		end
	end

	a_wr_not_entry0: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> wr_addr != '0)
		else $error("write aimed at the fixed SIG entry");

	a_wr_free_only: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !valid_q[wr_addr])
		else $error("write replaced a valid entry");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, rd_addr} < (IDX_W+1)'(ENTRIES))
		else $error("read address beyond the table");

endmodule

`default_nettype wire

FILE: hw/rtl/ubt_unit.sv
// Shared unit: 128-bit entry compare and short UUID overlay.
`default_nettype none

module ubt_unit
	import ubt_pkg::*;
(
	input  ubt_uuid_t         key,
	input  ubt_uuid_t         ent,
	input  wire logic         ent_valid,
	input  wire logic [31:0]  short_value,
	input  wire logic         short_is_32,
	output logic              hit,
	output ubt_uuid_t         expd
);

	always_comb begin
		hit     = ent_valid && (ent == key);
		expd.lo = ent.lo;
		if (short_is_32) begin
			expd.hi = {short_value, ent.hi[31:0]};
		end else begin
			expd.hi = {ent.hi[63:48], short_value[15:0], ent.hi[31:0]};
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/uuid_base_table.sv
// Top level of the UUID base table: request sequencer and result register.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid / in_ready   | req_type uuid_low uuid_high base_index
//           |                       | short_value short_is_32
//   out     | out_valid / out_ready | status found_index short_out full_low
//           |                       | full_high
//
// Find, add and compress walk the table one entry at a time (registered
// read, then compare), from entry 0 up to the last; a hit ends the walk
// early. Get, expand and unknown requests do a single read and compare.
// Reset leaves only entry 0 (the SIG base) valid; no clearing pass is needed.
// in_ready is high only while no request is in progress. A result waiting on
// out_ready holds the sequencer at its last step until the output beat frees.
`default_nettype none

module uuid_base_table
	import ubt_pkg::*;
#(
	parameter int ENTRIES = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  req_type,
	input  wire logic [63:0] uuid_low,
	input  wire logic [63:0] uuid_high,
	input  wire logic [7:0]  base_index,
	input  wire logic [31:0] short_value,
	input  wire logic        short_is_32,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [7:0]       found_index,
	output logic [15:0]      short_out,
	output logic [63:0]      full_low,
	output logic [63:0]      full_high
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [1:0] {
		IDLE,
		READ,
		CMP
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] k_q;
	logic [2:0]       req_q;
	ubt_uuid_t        key_q;
	logic             idx_ok_q;
	logic [31:0]      sv_q;
	logic             is32_q;
	logic [15:0]      sout_q;
	logic [IDX_W-1:0] free_q;
	logic             free_hit_q;

	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [7:0]       found_q;
	logic [15:0]      short_q;
	ubt_uuid_t        full_q;

	ubt_uuid_t        rd_data;
	logic             rd_valid;
	logic             hit;
	ubt_uuid_t        expd;

	logic             is_search;
	logic             last;
	logic             slot_free;
	logic             new_free;
	logic             fin;
	logic             go;
	logic             wr_en;
	logic [IDX_W-1:0] free_idx;
	logic [1:0]       r_status;
	logic [7:0]       r_found;
	ubt_uuid_t        r_full;

	ubt_store #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_addr    (k_q),
		.rd_data_q  (rd_data),
		.rd_valid_q (rd_valid),
		.wr_en      (wr_en),
		.wr_addr    (free_idx),
		.wr_data    (key_q)
	);

	ubt_unit u_unit (
		.key         (key_q),
		.ent         (rd_data),
		.ent_valid   (rd_valid),
		.short_value (sv_q),
		.short_is_32 (is32_q),
		.hit         (hit),
		.expd        (expd)
	);

	always_comb begin
		is_search = (req_q == REQ_FIND) || (req_q == REQ_ADD) || (req_q == REQ_COMP);
		last      = (k_q == IDX_W'(ENTRIES - 1));
		slot_free = !out_valid_q || out_ready;
		new_free  = (k_q != '0) && !rd_valid && !free_hit_q;
		free_idx  = free_hit_q ? free_q : k_q;
		fin       = 1'b0;
		wr_en     = 1'b0;
		r_status  = ST_BADIDX;
		r_found   = '0;
		r_full    = '0;
		if (state_q == CMP) begin
			if (is_search) begin
				if (hit) begin
					fin      = 1'b1;
					r_status = ST_OK;
					r_found  = 8'(k_q);
				end else if (last) begin
					fin = 1'b1;
					if (req_q == REQ_FIND) begin
						r_status = ST_NOTFOUND;
					end else if (free_hit_q || new_free) begin
						r_status = ST_OK;
						r_found  = 8'(free_idx);
						wr_en    = slot_free;
					end else begin
						r_status = ST_FULL;
						r_found  = (req_q == REQ_COMP) ? 8'(ENTRIES) : 8'd0;
					end
				end
			end else begin
				fin = 1'b1;
				if ((req_q == REQ_GET || req_q == REQ_EXPAND) && idx_ok_q && rd_valid) begin
					r_status = ST_OK;
					r_full   = (req_q == REQ_EXPAND) ? expd : rd_data;
				end
			end
		end
		go = fin && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			k_q         <= '0;
			free_hit_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result loaded in the same cycle keeps the output beat valid.
			if (out_valid_q && out_ready && !go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						req_q      <= req_type;
						sv_q       <= short_value;
						is32_q     <= short_is_32;
						idx_ok_q   <= base_index < 8'(ENTRIES);
						free_hit_q <= 1'b0;
						key_q.lo   <= uuid_low;
						// Compress looks up the base with bytes 12-13 cleared.
						if (req_type == REQ_COMP) begin
							key_q.hi <= uuid_high & SHORT16_CLEAR;
							sout_q   <= uuid_high[47:32];
						end else begin
							key_q.hi <= uuid_high;
							sout_q   <= '0;
						end
						if ((req_type == REQ_GET || req_type == REQ_EXPAND)
								&& base_index < 8'(ENTRIES)) begin
							k_q <= base_index[IDX_W-1:0];
						end else begin
							k_q <= '0;
						end
						state_q <= READ;
					end
				end
				READ: begin
					state_q <= CMP;
				end
				CMP: begin
					if (go) begin
						out_valid_q <= 1'b1;
						status_q    <= r_status;
						found_q     <= r_found;
						short_q     <= sout_q;
						full_q      <= r_full;
						state_q     <= IDLE;
					end else if (!fin) begin
						if (new_free) begin
							free_hit_q <= 1'b1;
							free_q     <= k_q;
						end
						k_q     <= k_q + 1'b1;
						state_q <= READ;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign short_out   = short_q;
	assign full_low    = full_q.lo;
	assign full_high   = full_q.hi;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sequencer took a beat but did not start work");

	a_ok_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |-> found_index < 8'(ENTRIES))
		else $error("ok result names an index beyond the table");

	a_fail_no_uuid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (full_low == '0 && full_high == '0))
		else $error("failed request carries uuid data");

	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> !wr_en)
		else $error("table filled twice for one request");

endmodule

`default_nettype wire
